// File: rtl/dtrie_pkg.sv
// Package for the DNA word trie: widths, letter codes, opcodes, controller states,
// and the command and status structs that link the controller to the datapath.
// Depends on nothing; every other file of the block uses it but rtl/dtrie_checker.sv.
package dtrie_pkg;

    localparam int NODE_COUNT_DEF = 256;
    localparam int LIMIT_W        = 9;
    localparam int SYM_W          = 8;
    localparam int SLOT_W         = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [SYM_W-1:0] SYM_A = 8'h61;
    localparam logic [SYM_W-1:0] SYM_C = 8'h63;
    localparam logic [SYM_W-1:0] SYM_T = 8'h74;
    localparam logic [SYM_W-1:0] SYM_G = 8'h67;

    localparam logic [SLOT_W-1:0] SLOT_A = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_C = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_T = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_G = 2'd3;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } dtrie_state_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic commit;
    } dtrie_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic item_last;
        logic out_busy;
    } dtrie_sts_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } dtrie_slot_t;

    // Maps a byte to its child slot; bytes outside the alphabet are not valid.
    function automatic dtrie_slot_t letter_slot(input logic [SYM_W-1:0] sym);
        dtrie_slot_t res;
        res.valid = 1'b1;
        res.slot  = SLOT_A;
        unique case (sym)
            SYM_A:   res.slot = SLOT_A;
            SYM_C:   res.slot = SLOT_C;
            SYM_T:   res.slot = SLOT_T;
            SYM_G:   res.slot = SLOT_G;
            default: res.valid = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/dtrie_if.sv
// Handshake channels of the DNA word trie: request, response and configuration.
// Depends on dtrie_pkg for the field widths.
interface dtrie_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [dtrie_pkg::SYM_W-1:0] symbol;
    logic                        last;

    modport source (output valid, output opcode, output symbol, output last, input ready);
    modport sink (input valid, input opcode, input symbol, input last, output ready);
endinterface

interface dtrie_rsp_if;
    logic valid;
    logic ready;
    logic found;
    logic overflow;

    modport source (output valid, output found, output overflow, input ready);
    modport sink (input valid, input found, input overflow, output ready);
endinterface

interface dtrie_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [dtrie_pkg::LIMIT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dna_trie_insert_lookup.sv
// DNA word trie, insert and lookup, one word byte per request word.
// Each request word takes two steps, accept with the child-link read and then commit;
// the next word is taken only after that commit.  A last byte holds in its commit step
// while the previous response word is not yet taken; its response is registered at commit.
// Reset: asynchronous rst_n; afterwards a clearing pass zeroes all 4*NODE_COUNT entries of
// the child-link memory, during which no request word is taken (configuration still is).
module dna_trie_insert_lookup
#(
    parameter int NODE_COUNT = dtrie_pkg::NODE_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    dtrie_req_if.sink   req,
    dtrie_rsp_if.source rsp,
    dtrie_cfg_if.sink   cfg
);

    // The controller sequences each request word through two steps.  In the
    // accept step the byte is decoded to a child slot and, when it is valid and the walk is
    // still live, the child link of the current node is read from memory.
    // In the commit step the link is followed, a node is allocated for an
    // insert where the link is missing, or the word is stopped on a lookup
    // miss or when the node limit is reached.  On the last byte the result
    // is loaded into the response register and the walk returns to the root.

    dtrie_pkg::dtrie_cmd_t cmd;
    dtrie_pkg::dtrie_sts_t sts;

    // The node limit register takes a write in every cycle.
    assign cfg.ready = 1'b1;

    dtrie_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dtrie_dp
    #(
        .NODE_COUNT (NODE_COUNT)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .req_opcode   (req.opcode),
        .req_symbol   (req.symbol),
        .req_last     (req.last),
        .cfg_valid    (cfg.valid),
        .cfg_data     (cfg.data),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_found    (rsp.found),
        .out_overflow (rsp.overflow)
    );

endmodule

// File: rtl/dtrie_ctrl.sv
// Controller of the DNA word trie: clearing pass, word accept and commit sequencing.
// Depends on dtrie_pkg for the state type and the command and status structs.
module dtrie_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  dtrie_pkg::dtrie_sts_t sts,
    output dtrie_pkg::dtrie_cmd_t cmd
);

    dtrie_pkg::dtrie_state_t state_reg;
    dtrie_pkg::dtrie_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dtrie_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            dtrie_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = dtrie_pkg::ST_IDLE;
                end
            end
            dtrie_pkg::ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = dtrie_pkg::ST_EXEC;
                end
            end
            dtrie_pkg::ST_EXEC:
            begin
                // A last word waits here while the previous result is still held.
                if (!sts.item_last || !sts.out_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = dtrie_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dtrie_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/dtrie_dp.sv
// Datapath of the DNA word trie: child-link memory, walk registers, allocator,
// node limit register and result register.  Depends on dtrie_pkg.
module dtrie_dp
#(
    parameter int NODE_COUNT = dtrie_pkg::NODE_COUNT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dtrie_pkg::dtrie_cmd_t         cmd,
    output dtrie_pkg::dtrie_sts_t         sts,
    input  logic                          req_opcode,
    input  logic [dtrie_pkg::SYM_W-1:0]   req_symbol,
    input  logic                          req_last,
    input  logic                          cfg_valid,
    input  logic [dtrie_pkg::LIMIT_W-1:0] cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          out_found,
    output logic                          out_overflow
);

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int AW    = NW + dtrie_pkg::SLOT_W;
    localparam int DEPTH = NODE_COUNT * 4;
    localparam int CW    = (NW + 1 > dtrie_pkg::LIMIT_W) ? NW + 1 : dtrie_pkg::LIMIT_W;

    // Each entry holds a child id and the word-end mark of that child.
    logic [NW:0] mem [DEPTH];

    logic [dtrie_pkg::LIMIT_W-1:0] limit_reg;
    logic                          op_reg;
    logic                          last_reg;
    logic [dtrie_pkg::SLOT_W-1:0]  slot_reg;
    logic                          active_reg;
    logic [NW:0]                   rdata_reg;
    logic [NW-1:0]                 cur_node_reg;
    logic [AW-1:0]                 cur_pos_reg;
    logic                          cur_mark_reg;
    logic                          at_root_reg;
    logic                          root_mark_reg;
    logic [NW:0]                   next_free_reg;
    logic                          miss_reg;
    logic                          ovf_reg;
    logic [AW-1:0]                 clr_cnt_reg;
    logic                          out_valid_reg;
    logic                          found_reg;
    logic                          overflow_reg;

    dtrie_pkg::dtrie_slot_t in_slot;
    logic                   in_active;
    logic [AW-1:0]          pos;
    logic [NW-1:0]          child;
    logic                   link;
    logic                   can_alloc;
    logic                   alloc;
    logic                   miss_next;
    logic                   ovf_next;
    logic [NW-1:0]          node_next;
    logic [AW-1:0]          pos_next;
    logic                   mark_next;
    logic                   root_next;
    logic                   word_ok;
    logic                   set_mark;
    logic                   found_next;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [NW:0]            wr_data;

    assign in_slot   = dtrie_pkg::letter_slot(req_symbol);
    assign in_active = in_slot.valid && !miss_reg && !ovf_reg;

    assign pos       = {cur_node_reg, slot_reg};
    assign child     = rdata_reg[NW-1:0];
    assign link      = active_reg && (child != '0);
    assign can_alloc = (CW'(next_free_reg) < CW'(limit_reg)) &&
                       (CW'(next_free_reg) < CW'(NODE_COUNT));
    assign alloc     = active_reg && !link && (op_reg == dtrie_pkg::OP_INSERT) && can_alloc;
    assign miss_next = miss_reg ||
                       (active_reg && !link && (op_reg == dtrie_pkg::OP_LOOKUP));
    assign ovf_next  = ovf_reg ||
                       (active_reg && !link && (op_reg == dtrie_pkg::OP_INSERT) && !can_alloc);

    always_comb
    begin
        node_next = cur_node_reg;
        pos_next  = cur_pos_reg;
        mark_next = cur_mark_reg;
        root_next = at_root_reg;
        if (link)
        begin
            node_next = child;
            pos_next  = pos;
            mark_next = rdata_reg[NW];
            root_next = 1'b0;
        end
        else if (alloc)
        begin
            node_next = next_free_reg[NW-1:0];
            pos_next  = pos;
            mark_next = 1'b0;
            root_next = 1'b0;
        end
    end

    assign word_ok  = !miss_next && !ovf_next;
    assign set_mark = last_reg && (op_reg == dtrie_pkg::OP_INSERT) && word_ok;

    always_comb
    begin
        if (op_reg == dtrie_pkg::OP_LOOKUP)
        begin
            found_next = word_ok && (root_next ? root_mark_reg : mark_next);
        end
        else
        begin
            found_next = word_ok;
        end
    end

    // One write port: zeroing during the clearing pass, else allocation and marking.
    always_comb
    begin
        if (cmd.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = cmd.commit && (alloc || (set_mark && !root_next));
            wr_addr = pos_next;
            wr_data = {set_mark, node_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.accept && in_active)
        begin
            rdata_reg <= mem[{cur_node_reg, in_slot.slot}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= req_opcode;
            last_reg <= req_last;
            slot_reg <= in_slot.slot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && last_reg)
        begin
            found_reg    <= found_next;
            overflow_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= dtrie_pkg::LIMIT_RESET;
            active_reg    <= 1'b0;
            cur_node_reg  <= '0;
            cur_pos_reg   <= '0;
            cur_mark_reg  <= 1'b0;
            at_root_reg   <= 1'b1;
            root_mark_reg <= 1'b0;
            next_free_reg <= (NW + 1)'(1);
            miss_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                active_reg <= in_active;
            end
            if (cmd.commit)
            begin
                if (alloc)
                begin
                    next_free_reg <= next_free_reg + (NW + 1)'(1);
                end
                if (last_reg)
                begin
                    if (set_mark && root_next)
                    begin
                        root_mark_reg <= 1'b1;
                    end
                    cur_node_reg <= '0;
                    cur_pos_reg  <= '0;
                    cur_mark_reg <= 1'b0;
                    at_root_reg  <= 1'b1;
                    miss_reg     <= 1'b0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    cur_node_reg <= node_next;
                    cur_pos_reg  <= pos_next;
                    cur_mark_reg <= mark_next;
                    at_root_reg  <= root_next;
                    miss_reg     <= miss_next;
                    ovf_reg      <= ovf_next;
                end
            end
            if (cmd.commit && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clear_done = (clr_cnt_reg == AW'(DEPTH - 1));
    assign sts.item_last  = last_reg;
    assign sts.out_busy   = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_overflow = overflow_reg;

endmodule

// File: rtl/dtrie_checker.sv
// Port-level checks of the DNA word trie, attached to the top level by bind.
// Depends on the top level's channel signals only.
module dtrie_checker
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic req_last,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic rsp_found,
    input logic rsp_overflow
);

    // The block never takes request words back to back.
    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    // A held response stays until taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // A new response must be caused by an accepted last byte.
    a_rsp_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2))
        else $error("response without a last byte");

    // A word stopped by the node limit never reports found.
    a_found_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_found && rsp_overflow))
        else $error("found and overflow both set");

endmodule

bind dna_trie_insert_lookup dtrie_checker u_dtrie_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_last     (req.last),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_overflow (rsp.overflow)
);

// File: sim/dtrie_answer_check.sv
`timescale 1ns / 100ps
// Checker for the DNA word trie: watches the request, response and configuration channels.
// It predicts the response words, compares them field by field and reports a failure count.
// Depends on dtrie_pkg and the channel interfaces in rtl/dtrie_if.sv.
module dtrie_answer_check
#(
    parameter int NODES = dtrie_pkg::NODE_COUNT_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    dtrie_req_if  req,
    dtrie_rsp_if  rsp,
    dtrie_cfg_if  cfg,
    output int    fail_count,
    output int    pending
);

    import dtrie_pkg::*;

    typedef struct packed {
        logic found;
        logic overflow;
    } trie_answer_t;

    int                 child_link [NODES*4];
    bit                 word_mark [NODES];
    int                 walk_node;
    int                 free_node;
    bit                 miss_flag;
    bit                 ovf_flag;
    logic [LIMIT_W-1:0] limit_reg;
    trie_answer_t       answers_due [$];

    function automatic int symbol_slot(input logic [SYM_W-1:0] sym);
        case (sym)
            SYM_A:   return 0;
            SYM_C:   return 1;
            SYM_T:   return 2;
            SYM_G:   return 3;
            default: return -1;
        endcase
    endfunction

    // A limit above the node count is clipped, and zero still leaves the root.
    function automatic int usable_nodes();
        int lim;
        lim = int'(limit_reg);
        if (lim > NODES)
            lim = NODES;
        if (lim < 1)
            lim = 1;
        return lim;
    endfunction

    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] answer_check: %s", $time, what);
    endtask

    // Walks the trie by one request word and queues the answer on the last byte of a key.
    task automatic walk_trie(input logic op, input logic [SYM_W-1:0] sym, input logic fin);
        int           slot;
        int           pos;
        trie_answer_t ans;
        slot = symbol_slot(sym);
        if (slot >= 0 && !miss_flag && !ovf_flag)
        begin
            pos = walk_node * 4 + slot;
            if (child_link[pos] != 0)
                walk_node = child_link[pos];
            else if (op == OP_LOOKUP)
                miss_flag = 1'b1;
            else if (free_node < usable_nodes())
            begin
                child_link[pos] = free_node;
                walk_node = free_node;
                free_node++;
            end
            else
                ovf_flag = 1'b1;
        end
        if (fin)
        begin
            if (op == OP_LOOKUP)
                ans.found = !miss_flag && !ovf_flag && word_mark[walk_node];
            else if (!miss_flag && !ovf_flag)
            begin
                word_mark[walk_node] = 1'b1;
                ans.found = 1'b1;
            end
            else
                ans.found = 1'b0;
            ans.overflow = ovf_flag;
            answers_due.push_back(ans);
            walk_node = 0;
            miss_flag = 1'b0;
            ovf_flag  = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        trie_answer_t exp_ans;
        if (!rst_n)
        begin
            foreach (child_link[i])
                child_link[i] = 0;
            foreach (word_mark[i])
                word_mark[i] = 1'b0;
            walk_node  = 0;
            free_node  = 1;
            miss_flag  = 1'b0;
            ovf_flag   = 1'b0;
            limit_reg  = LIMIT_RESET;
            answers_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_reg = cfg.data;
            if (rsp.valid && rsp.ready)
            begin
                if (answers_due.size() == 0)
                    log_failure($sformatf("response word with none expected: found=%0b overflow=%0b",
                                          rsp.found, rsp.overflow));
                else
                begin
                    exp_ans = answers_due.pop_front();
                    if (rsp.found !== exp_ans.found)
                        log_failure($sformatf("found: expected %0b, got %0b",
                                              exp_ans.found, rsp.found));
                    if (rsp.overflow !== exp_ans.overflow)
                        log_failure($sformatf("overflow: expected %0b, got %0b",
                                              exp_ans.overflow, rsp.overflow));
                end
            end
            if (req.valid && req.ready)
                walk_trie(req.opcode, req.symbol, req.last);
            pending = answers_due.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the DNA word trie testbench: clock, reset, stimulus and the final verdict.
// Depends on dtrie_pkg, rtl/dtrie_if.sv, the block itself and sim/dtrie_answer_check.sv.
module tb_top;

    import dtrie_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 8;
    // The block clears its link memory after reset before it takes a request word, and
    // this timeout lies far beyond the slowest correct run.
    localparam int TIMEOUT_CYCLES = 300000;
    // A request word that ends no key may still be in flight when the last response
    // has come; this settle wait lets it finish, with margin.
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASES        = 6;
    localparam int BANK_DEPTH    = 48;

    // One request word as the directed part lists it.
    typedef struct packed {
        logic             op;
        logic [SYM_W-1:0] sym;
        logic             fin;
    } req_word_t;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle;
    int   recv_idle;
    bit   hold_request;

    // Stored keys let most lookups walk deep into paths that actually exist.
    bit [63:0] key_bank [$];
    int        key_len_bank [$];

    // Limit plan: a limit of one first, so the few nodes of the directed keys stay
    // reachable while every new node is refused; zero must act like one; the widest
    // value is clipped to the node count; the last two lower and then restore the limit.
    int limit_plan [PHASES] = '{1, 12, 0, 511, 200, 256};
    int keys_plan  [PHASES] = '{60, 140, 50, 200, 110, 60};

    // Directed words: empty keys on the bare root, a plain insert and its lookups, a
    // prefix that is no key, skipped bytes inside a key, a lookup miss followed by an
    // insert byte, an insert byte followed by a lookup miss, and a miss deep in a path.
    req_word_t directed_words [25] = '{
        '{OP_LOOKUP, 8'h00, 1'b1},
        '{OP_INSERT, 8'hFF, 1'b1},
        '{OP_LOOKUP, 8'h78, 1'b1},
        '{OP_INSERT, SYM_A, 1'b0}, '{OP_INSERT, SYM_C, 1'b0}, '{OP_INSERT, SYM_G, 1'b1},
        '{OP_LOOKUP, SYM_A, 1'b0}, '{OP_LOOKUP, SYM_C, 1'b0}, '{OP_LOOKUP, SYM_G, 1'b1},
        '{OP_LOOKUP, SYM_A, 1'b0}, '{OP_LOOKUP, SYM_C, 1'b1},
        '{OP_INSERT, SYM_T, 1'b0}, '{OP_INSERT, 8'h80, 1'b0}, '{OP_INSERT, SYM_G, 1'b1},
        '{OP_LOOKUP, SYM_T, 1'b0}, '{OP_LOOKUP, 8'h01, 1'b0}, '{OP_LOOKUP, SYM_G, 1'b1},
        '{OP_LOOKUP, SYM_C, 1'b0}, '{OP_INSERT, SYM_A, 1'b1},
        '{OP_INSERT, SYM_G, 1'b0}, '{OP_LOOKUP, SYM_G, 1'b1},
        '{OP_LOOKUP, SYM_A, 1'b0}, '{OP_LOOKUP, SYM_C, 1'b0}, '{OP_LOOKUP, SYM_G, 1'b0},
        '{OP_LOOKUP, SYM_T, 1'b1}
    };

    dtrie_req_if req_ch ();
    dtrie_rsp_if rsp_ch ();
    dtrie_cfg_if cfg_ch ();

    dna_trie_insert_lookup dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    dtrie_answer_check answer_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // Response side. Ready moves only at the falling edge. A long hold, counted here,
    // lets the block's output back up so that it has to stall the request channel.
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                rsp_ch.ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Offers one request word, with random gaps first, and returns at the falling edge
    // after it has been taken. Valid stays high into the next word when no gap follows.
    task automatic put_word(input logic op, input logic [SYM_W-1:0] sym, input logic fin);
        while ($urandom_range(0, 99) < send_idle)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.opcode <= op;
        req_ch.symbol <= sym;
        req_ch.last   <= fin;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stops offering words until every expected response word has arrived.
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // The limit is only changed while the block is idle.
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        wait_all_answered();
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [SYM_W-1:0] pick_letter();
        case ($urandom_range(0, 3))
            0:       return SYM_A;
            1:       return SYM_C;
            2:       return SYM_T;
            default: return SYM_G;
        endcase
    endfunction

    // Mostly short keys of letters, a few of the longest length, some stray bytes
    // inside them, and now and then an empty key (one skipped byte marked last).
    task automatic make_key(output bit [63:0] key, output int len);
        int i;
        int r;
        key = '0;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            len = 1;
            key[7:0] = 8'($urandom_range(0, 255));
            if (key[7:0] == SYM_A || key[7:0] == SYM_C || key[7:0] == SYM_T ||
                key[7:0] == SYM_G)
                key[7:0] = 8'hFF;
        end
        else
        begin
            len = (r < 8) ? 8 : $urandom_range(1, 6);
            for (i = 0; i < len; i++)
                key[8*i +: 8] = ($urandom_range(0, 99) < 88) ? pick_letter()
                                                              : 8'($urandom_range(0, 255));
        end
    endtask

    // Sends a key byte by byte. A mixed key gives every byte an opcode of its own.
    task automatic send_key(input bit [63:0] key, input int len, input logic op,
                            input bit mixed);
        int   i;
        logic word_op;
        for (i = 0; i < len; i++)
        begin
            word_op = mixed ? logic'($urandom_range(0, 1)) : op;
            put_word(word_op, key[8*i +: 8], i == len - 1);
        end
    endtask

    // Half the keys are inserts of fresh keys, half are lookups, mostly of stored keys
    // or their prefixes, so both hits and misses at every depth are common.
    task automatic random_key();
        bit [63:0] key;
        int        len;
        int        pick;
        logic      op;
        bit        mixed;
        op    = ($urandom_range(0, 1) == 1) ? OP_LOOKUP : OP_INSERT;
        mixed = ($urandom_range(0, 99) < 8);
        make_key(key, len);
        if (op == OP_LOOKUP && key_bank.size() != 0 && $urandom_range(0, 99) < 70)
        begin
            pick = $urandom_range(0, key_bank.size() - 1);
            key  = key_bank[pick];
            len  = key_len_bank[pick];
            if ($urandom_range(0, 99) < 20)
                len = $urandom_range(1, len);
        end
        else if (op == OP_INSERT)
        begin
            key_bank.push_back(key);
            key_len_bank.push_back(len);
            if (key_bank.size() > BANK_DEPTH)
            begin
                void'(key_bank.pop_front());
                void'(key_len_bank.pop_front());
            end
        end
        send_key(key, len, op, mixed);
    endtask

    initial
    begin
        int p;
        int k;
        int i;
        rst_n         = 1'b0;
        hold_request  = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.opcode = OP_INSERT;
        req_ch.symbol = '0;
        req_ch.last   = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = LIMIT_RESET;
        send_idle     = 14;
        recv_idle     = 58;

        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n = 1'b1;

        // Directed words run under the limit left by reset.
        foreach (directed_words[d])
            put_word(directed_words[d].op, directed_words[d].sym, directed_words[d].fin);

        for (p = 0; p < PHASES; p++)
        begin
            write_limit(limit_plan[p][LIMIT_W-1:0]);
            // Sender light and receiver heavy, then the reverse, then no idling at all.
            if (p < 2)
            begin
                send_idle = 14;
                recv_idle = 58;
            end
            else if (p < 4)
            begin
                send_idle = 58;
                recv_idle = 14;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end

            for (k = 0; k < keys_plan[p]; k++)
            begin
                if (p == 3 && k == 20)
                begin
                    // Keep the response side stalled while one-letter lookups pile up,
                    // so the block fills and has to refuse request words.
                    hold_request = 1'b1;
                    for (i = 0; i < 16; i++)
                        put_word(OP_LOOKUP, pick_letter(), 1'b1);
                end
                if ((p == 1 && k == 70) || $urandom_range(0, 99) < 2)
                    wait_all_answered();
                random_key();
            end
        end

        wait_all_answered();
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dtrie_pkg.sv
rtl/dtrie_if.sv
rtl/dtrie_ctrl.sv
rtl/dtrie_dp.sv
rtl/dna_trie_insert_lookup.sv
rtl/dtrie_checker.sv
sim/dtrie_answer_check.sv
sim/tb_top.sv
